@@ sv/tlpp_pkg.sv @@
// shared types and constants for the trace lobe peak picker
package tlpp_pkg;

  // sample index field width and default trace length
  localparam int unsigned POS_W               = 12;
  localparam int unsigned MAG_W               = 16;
  localparam int unsigned MAX_TRACE_LEN_DFLT  = 4096;

  // one input request: a trace sample and its start-of-trace flag
  typedef struct packed {
    logic signed [15:0] sample;
    logic               trace_start;
  } in_item_t;

  // one result request: peak index and polarity of a finished lobe
  typedef struct packed {
    logic [POS_W-1:0] peak_index;
    logic             peak_polarity;
  } out_item_t;

endpackage

@@ sv/trace_lobe_peak_picker_top.sv @@
// top level of the trace lobe peak picker: input stage, tracker, result register
//
// channel | direction | payload          | handshake
// in_     | input     | sample, start    | in_valid / in_stall
// out_    | output    | peak index, pol  | out_valid / out_stall
//
// one sample request is taken every cycle while the result side keeps up
// a result is loaded into the result register when the sample that finishes its lobe leaves the input register
// the tracker's single compare-and-update step per sample sets the rate
// synchronous active-low reset empties both stages and reopens the first trace
// a held result only stalls input when the staged sample would finish a lobe
module trace_lobe_peak_picker_top #(
  parameter int unsigned MAX_TRACE_LEN = tlpp_pkg::MAX_TRACE_LEN_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpp_pkg::out_item_t out_item
);
  import tlpp_pkg::*;

  logic      stg_valid_r, stg_valid_nxt;
  in_item_t  stg_item_r;
  logic      res_valid_r, res_valid_nxt;
  out_item_t res_item_r;

  logic      emit;
  out_item_t result;
  logic      res_free;
  logic      step;
  logic      in_take;

  // staged sample moves on unless it finishes a lobe into a held result
  assign res_free = !res_valid_r || !out_stall;
  assign step     = stg_valid_r && (!emit || res_free);
  assign in_stall = stg_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  tlpp_lobe #(
    .MAX_TRACE_LEN (MAX_TRACE_LEN)
  ) u_lobe (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (stg_item_r),
    .emit   (emit),
    .result (result)
  );

  // valid bits of both stages
  always_comb begin
    stg_valid_nxt = in_take || (stg_valid_r && !step);
    res_valid_nxt = (step && emit) || (res_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_item_r <= in_item;
    end
    if (step && emit) begin
      res_item_r <= result;
    end
  end

  assign out_valid = res_valid_r;
  assign out_item  = res_item_r;

  // an empty input stage never stalls the sender
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |-> !in_stall)
    else $error("input stalled with empty stage");

  // a new result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && out_stall) |-> !(step && emit))
    else $error("held result overwritten");

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

@@ sv/tlpp_lobe.sv @@
// lobe tracker: sign class, running peak and sample index per trace
module tlpp_lobe #(
  parameter int unsigned MAX_TRACE_LEN = tlpp_pkg::MAX_TRACE_LEN_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tlpp_pkg::in_item_t  item,
  output logic                emit,
  output tlpp_pkg::out_item_t result
);
  import tlpp_pkg::*;

  // index saturates at the smaller of the last trace index and the field range
  localparam int unsigned FieldMax = (1 << POS_W) - 1;
  localparam int unsigned CapInt   = (MAX_TRACE_LEN - 1 < FieldMax) ?
                                     (MAX_TRACE_LEN - 1) : FieldMax;
  localparam logic [POS_W-1:0] PosCap = POS_W'(CapInt);

  logic             lobe_pos_r,  lobe_pos_nxt;
  logic [MAG_W-1:0] best_mag_r,  best_mag_nxt;
  logic [POS_W-1:0] best_pos_r,  best_pos_nxt;
  logic [POS_W-1:0] sample_pos_r, sample_pos_nxt;
  logic             trace_open_r, trace_open_nxt;

  logic             negative;
  logic             pos_class;
  logic [MAG_W-1:0] mag;
  logic             first;
  logic [POS_W-1:0] pos_inc;

  // classify the sample and take its magnitude (-32768 gives 0x8000)
  assign negative  = item.sample[15];
  assign pos_class = !negative && (item.sample != '0);
  assign mag       = negative ? MAG_W'(-item.sample) : MAG_W'(item.sample);
  assign first     = item.trace_start || !trace_open_r;
  assign pos_inc   = (sample_pos_r < PosCap) ? (sample_pos_r + 1'b1) : sample_pos_r;

  // a class change inside an open trace finishes the current lobe
  assign emit                 = !first && (pos_class != lobe_pos_r);
  assign result.peak_index    = best_pos_r;
  assign result.peak_polarity = lobe_pos_r;

  // next state of the tracker
  always_comb begin
    lobe_pos_nxt   = lobe_pos_r;
    best_mag_nxt   = best_mag_r;
    best_pos_nxt   = best_pos_r;
    sample_pos_nxt = sample_pos_r;
    trace_open_nxt = trace_open_r;
    if (step) begin
      priority if (first) begin
        trace_open_nxt = 1'b1;
        sample_pos_nxt = '0;
        lobe_pos_nxt   = pos_class;
        best_mag_nxt   = mag;
        best_pos_nxt   = '0;
      end else if (pos_class == lobe_pos_r) begin
        sample_pos_nxt = pos_inc;
        if (mag > best_mag_r) begin
          best_mag_nxt = mag;
          best_pos_nxt = pos_inc;
        end
      end else begin
        sample_pos_nxt = pos_inc;
        lobe_pos_nxt   = pos_class;
        best_mag_nxt   = mag;
        best_pos_nxt   = pos_inc;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lobe_pos_r   <= 1'b0;
      best_mag_r   <= '0;
      best_pos_r   <= '0;
      sample_pos_r <= '0;
      trace_open_r <= 1'b0;
    end else begin
      lobe_pos_r   <= lobe_pos_nxt;
      best_mag_r   <= best_mag_nxt;
      best_pos_r   <= best_pos_nxt;
      sample_pos_r <= sample_pos_nxt;
      trace_open_r <= trace_open_nxt;
    end
  end

  // a finished lobe is always followed by one of the other class
  a_emit_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit) |=> (lobe_pos_r != $past(lobe_pos_r)))
    else $error("lobe class did not change after a finished lobe");

  // the sample index never passes its cap
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sample_pos_r <= PosCap)
    else $error("sample index beyond cap");

  // the peak lies at or before the latest sample
  a_peak_order: assert property (@(posedge clk) disable iff (!rst_n)
    best_pos_r <= sample_pos_r)
    else $error("peak index ahead of sample index");

endmodule

@@ dv/lobe_peak_check_pkg.sv @@
// scoreboard for the trace lobe peak picker: lobe tracking and expected peak queue
package lobe_peak_check_pkg;

  import tlpp_pkg::*;

  class lobe_peak_scoreboard;
    // tracker copy: class, best magnitude and index of the open lobe
    bit               lobe_positive;
    logic [16:0]      best_mag;
    logic [POS_W-1:0] best_pos;
    logic [POS_W-1:0] sample_pos;
    bit               trace_open;
    int unsigned      pos_cap;
    out_item_t        peak_queue[$];
    int unsigned      failures;
    int unsigned      reported;

    function new(int unsigned max_trace_len);
      pos_cap = max_trace_len - 1;
      if (pos_cap > (2 ** POS_W) - 1) begin
        pos_cap = (2 ** POS_W) - 1;
      end
      lobe_positive = 1'b0;
      best_mag      = '0;
      best_pos      = '0;
      sample_pos    = '0;
      trace_open    = 1'b0;
      failures      = 0;
      reported      = 0;
    endfunction

    // update the lobe state for one accepted sample request
    function void note_sample(in_item_t req);
      logic [15:0] raw;
      logic [16:0] mag;
      bit          neg;
      bit          is_pos;
      out_item_t   peak;
      raw    = req.sample;
      neg    = raw[15];
      mag    = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      is_pos = !neg && (raw != 16'h0000);

      // trace start, or the first sample ever: restart the lobe at index zero
      if (req.trace_start || !trace_open) begin
        trace_open    = 1'b1;
        sample_pos    = '0;
        lobe_positive = is_pos;
        best_mag      = mag;
        best_pos      = '0;
        return;
      end

      // index saturates at the cap
      if (sample_pos < pos_cap) begin
        sample_pos = sample_pos + 1'b1;
      end

      // same class: keep the earlier index on a tie
      if (is_pos == lobe_positive) begin
        if (mag > best_mag) begin
          best_mag = mag;
          best_pos = sample_pos;
        end
        return;
      end

      // class change closes the lobe
      peak.peak_index    = best_pos;
      peak.peak_polarity = lobe_positive;
      peak_queue = {peak_queue, peak};
      lobe_positive = is_pos;
      best_mag      = mag;
      best_pos      = sample_pos;
    endfunction

    // compare one accepted result request against the oldest expected peak
    function void check_peak(out_item_t got);
      out_item_t want;
      if (peak_queue.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected peak: index %0d polarity %0d",
                   got.peak_index, got.peak_polarity);
        end
        return;
      end
      want = peak_queue.pop_front();
      if (got.peak_index !== want.peak_index || got.peak_polarity !== want.peak_polarity) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("peak mismatch: expected index %0d polarity %0d, got index %0d polarity %0d",
                   want.peak_index, want.peak_polarity, got.peak_index, got.peak_polarity);
        end
      end
    endfunction

    function int unsigned pending();
      return peak_queue.size();
    endfunction

    // peaks that never arrived
    function void close_out();
      if (peak_queue.size() != 0) begin
        failures += peak_queue.size();
        $display("%0d expected peaks never arrived", peak_queue.size());
      end
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
// testbench for the trace lobe peak picker: directed and random traces, idling and hold-off
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import tlpp_pkg::*;
  import lobe_peak_check_pkg::*;

  localparam int unsigned TRACE_LEN = MAX_TRACE_LEN_DFLT;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int unsigned out_hold = 0;

  lobe_peak_scoreboard sb = new(TRACE_LEN);

  trace_lobe_peak_picker_top #(
    .MAX_TRACE_LEN(TRACE_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: check on accept, stall at random or during a hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_peak(out_item);
      end
      @(negedge clk);
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
      end
    end
  end

  // offer one sample request and hold it until taken; entered and left at a falling edge
  task automatic send_sample(input logic signed [15:0] s, input logic st);
    in_item_t req;
    bit       taken;
    req.sample      = s;
    req.trace_start = st;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do begin
      @(posedge clk);
      taken = !in_stall;
      if (taken) begin
        sb.note_sample(req);
      end
      @(negedge clk);
    end while (!taken);
  endtask

  // random amplitude of the given class, biased toward extremes and small ties
  function automatic logic signed [15:0] pick_sample(bit positive);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (positive) begin
      if (r == 0) return 16'sh7fff;
      if (r < 4) return 16'($urandom_range(1, 8));
      return 16'($urandom_range(1, 32767));
    end
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh0000;
    if (r < 5) return 16'(-int'($urandom_range(0, 8)));
    return 16'(-int'($urandom_range(1, 32768)));
  endfunction

  // one trace of lobes with random run lengths, a little noise and stray start flags
  task automatic send_trace(input int unsigned len, input bit flag, input int unsigned max_run);
    bit             positive;
    int unsigned    run;
    logic signed [15:0] s;
    logic           st;
    positive = $urandom_range(0, 1);
    run      = $urandom_range(1, max_run);
    for (int unsigned i = 0; i < len; i++) begin
      if (run == 0) begin
        positive = !positive;
        run      = $urandom_range(1, max_run);
      end
      if ($urandom_range(0, 19) == 0) begin
        s = 16'($urandom);
      end else begin
        s = pick_sample(positive);
      end
      st = (i == 0) ? flag : ($urandom_range(0, 49) == 0);
      send_sample(s, st);
      run--;
    end
  endtask

  // sender pause until every expected peak has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int          idle_tab[4];
    int          stall_tab[4];
    idle_tab  = '{0, 71, 0, 17};
    stall_tab = '{0, 0, 71, 17};

    // reset
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: first sample without a flag, ties, extremes, dropped lobe, restarts
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b0);
    send_sample(16'sh2aaa, 1'b0);
    drain();

    // long hold-off on the result side while alternating lobes keep coming
    out_hold = 200;
    send_trace(60, 1'b1, 1);
    drain();

    // random traces under each idling mix
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = idle_tab[p];
      out_stall_pct = stall_tab[p];
      sent = 0;
      while (sent < 190) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
        // now and then a trace runs on without its start flag
        send_trace(len, ($urandom_range(0, 9) != 0), 8);
        sent += len;
      end
      drain();
    end

    repeat (8) @(negedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
